### rtl/core/ule_pkg.sv
// ============================================================================
// ule_pkg: shared constants and types of the UTF-8 line editor
// Key codes, store sizing, and the command/status bundles that join the
// line editor controller and its datapath.
// ============================================================================
package ule_pkg;

	// Line store sizing
	localparam int LINE_MAX = 64;
	localparam int ADDR_W   = $clog2(LINE_MAX);
	localparam int PTR_W    = $clog2(LINE_MAX + 1);

	// Key codes
	localparam logic [8:0] KEY_EOT       = 9'd4;
	localparam logic [8:0] KEY_BS        = 9'd8;
	localparam logic [8:0] KEY_TAB       = 9'd9;
	localparam logic [8:0] KEY_LF        = 9'd10;
	localparam logic [8:0] KEY_CR        = 9'd13;
	localparam logic [8:0] KEY_SUB       = 9'd26;
	localparam logic [8:0] KEY_ESC       = 9'd27;
	localparam logic [8:0] KEY_SPACE     = 9'd32;
	localparam logic [8:0] KEY_DEL       = 9'd127;
	localparam logic [8:0] KEY_LEFT      = 9'h100;
	localparam logic [8:0] KEY_RIGHT     = 9'h101;
	localparam logic [8:0] KEY_CSI       = 9'h05b; // '['
	localparam logic [8:0] KEY_SS3       = 9'h04f; // 'O'
	localparam logic [8:0] KEY_FIN_LO    = 9'h040;
	localparam logic [8:0] KEY_FIN_HI    = 9'h07e;
	localparam logic [8:0] KEY_FIN_LEFT  = 9'h044; // 'D'
	localparam logic [8:0] KEY_FIN_RIGHT = 9'h043; // 'C'

	// UTF-8 continuation byte: 10xxxxxx
	localparam logic [7:0] CONT_MASK = 8'hc0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	// Datapath operations
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD_LEFT,   // ptr = cur - 1
		DP_LOAD_RIGHT,  // ptr = cur + 1
		DP_PTR_DEC,
		DP_PTR_INC,
		DP_SET_CUR,     // cur = ptr
		DP_BKSP_START,  // cur = ptr, dst = ptr, ptr = old cur
		DP_COPY,        // store[dst] = rd, ptr++, dst++
		DP_BKSP_END,    // len = dst
		DP_INS_START,   // dst = len, ptr = len - 1, latch byte
		DP_SHIFT,       // store[dst] = rd, ptr--, dst--
		DP_INS_END,     // store[dst] = byte, cur++, len++
		DP_EMIT_START,  // ptr = 0
		DP_EMIT_BYTE,   // load output with rd, ptr++, clear line on last
		DP_EMIT_EMPTY,  // load output with the empty-line beat
		DP_EMIT_END     // load output with the end-of-input beat
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [7:0] data;
	} dp_cmd_t;

	typedef struct packed {
		logic len_zero;
		logic len_full;
		logic cur_zero;
		logic cur_at_end;
		logic ptr_zero;
		logic ptr_at_len;
		logic dst_at_cur;
		logic rd_cont;
		logic emit_last;
		logic out_free;
	} dp_stat_t;

endpackage

### rtl/core/ule_datapath.sv
// ============================================================================
// ule_datapath: line store, length/cursor registers and result register
// Executes one command per cycle from the controller. The store is read at
// the work pointer every cycle with registered data, and written at the
// destination pointer.
// ============================================================================
module ule_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  ule_pkg::dp_cmd_t cmd,
	output ule_pkg::dp_stat_t stat,
	input  logic             out_ready,
	output logic             out_valid,
	output logic             out_kind,
	output logic [7:0]       out_byte,
	output logic             out_empty,
	output logic             out_last
);

	logic [7:0] store_q [ule_pkg::LINE_MAX];
	logic [7:0] rd_q;
	logic [7:0] byte_q;
	logic [ule_pkg::PTR_W-1:0] len_q;
	logic [ule_pkg::PTR_W-1:0] cur_q;
	logic [ule_pkg::PTR_W-1:0] ptr_q;
	logic [ule_pkg::PTR_W-1:0] dst_q;
	logic [ule_pkg::PTR_W-1:0] ptr_inc;
	logic out_valid_q;
	logic out_load;

	assign ptr_inc = ptr_q + ule_pkg::PTR_W'(1);

	// Status back to the controller
	assign stat.len_zero   = (len_q == '0);
	assign stat.len_full   = (len_q == ule_pkg::PTR_W'(ule_pkg::LINE_MAX));
	assign stat.cur_zero   = (cur_q == '0);
	assign stat.cur_at_end = (cur_q == len_q);
	assign stat.ptr_zero   = (ptr_q == '0);
	assign stat.ptr_at_len = (ptr_q == len_q);
	assign stat.dst_at_cur = (dst_q == cur_q);
	assign stat.rd_cont    = ((rd_q & ule_pkg::CONT_MASK) == ule_pkg::CONT_TAG);
	assign stat.emit_last  = (ptr_inc == len_q);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_load = (cmd.op == ule_pkg::DP_EMIT_BYTE) ||
	                  (cmd.op == ule_pkg::DP_EMIT_EMPTY) ||
	                  (cmd.op == ule_pkg::DP_EMIT_END);

	// Line store: registered read at ptr, write at dst
	always_ff @(posedge clk) begin
		rd_q <= store_q[ptr_q[ule_pkg::ADDR_W-1:0]];
		if (cmd.op == ule_pkg::DP_COPY || cmd.op == ule_pkg::DP_SHIFT) begin
			store_q[dst_q[ule_pkg::ADDR_W-1:0]] <= rd_q;
		end else if (cmd.op == ule_pkg::DP_INS_END) begin
			store_q[dst_q[ule_pkg::ADDR_W-1:0]] <= byte_q;
		end
	end

	// Pointers and insert byte
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ule_pkg::DP_LOAD_LEFT:  ptr_q <= cur_q - ule_pkg::PTR_W'(1);
			ule_pkg::DP_LOAD_RIGHT: ptr_q <= cur_q + ule_pkg::PTR_W'(1);
			ule_pkg::DP_PTR_DEC:    ptr_q <= ptr_q - ule_pkg::PTR_W'(1);
			ule_pkg::DP_PTR_INC:    ptr_q <= ptr_inc;
			ule_pkg::DP_BKSP_START: begin
				ptr_q <= cur_q;
				dst_q <= ptr_q;
			end
			ule_pkg::DP_COPY: begin
				ptr_q <= ptr_inc;
				dst_q <= dst_q + ule_pkg::PTR_W'(1);
			end
			ule_pkg::DP_INS_START: begin
				dst_q  <= len_q;
				ptr_q  <= len_q - ule_pkg::PTR_W'(1);
				byte_q <= cmd.data;
			end
			ule_pkg::DP_SHIFT: begin
				ptr_q <= ptr_q - ule_pkg::PTR_W'(1);
				dst_q <= dst_q - ule_pkg::PTR_W'(1);
			end
			ule_pkg::DP_EMIT_START: ptr_q <= '0;
			ule_pkg::DP_EMIT_BYTE:  ptr_q <= ptr_inc;
			default: ;
		endcase
	end

	// Length and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cur_q <= '0;
		end else begin
			unique case (cmd.op) inside
				ule_pkg::DP_SET_CUR,
				ule_pkg::DP_BKSP_START: cur_q <= ptr_q;
				ule_pkg::DP_BKSP_END:   len_q <= dst_q;
				ule_pkg::DP_INS_END: begin
					cur_q <= cur_q + ule_pkg::PTR_W'(1);
					len_q <= len_q + ule_pkg::PTR_W'(1);
				end
				ule_pkg::DP_EMIT_BYTE: begin
					if (stat.emit_last) begin
						len_q <= '0;
						cur_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind  <= (cmd.op == ule_pkg::DP_EMIT_END);
			out_byte  <= (cmd.op == ule_pkg::DP_EMIT_BYTE) ? rd_q : 8'd0;
			out_empty <= (cmd.op == ule_pkg::DP_EMIT_EMPTY);
			out_last  <= (cmd.op == ule_pkg::DP_EMIT_BYTE) ? stat.emit_last : 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/ule_ctrl.sv
// ============================================================================
// ule_ctrl: line editor controller
// Decodes each key, runs the escape parser and the end-of-input flag, and
// sequences the datapath through cursor scans, shifts and line output.
// ============================================================================
module ule_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              ready,
	input  logic [8:0]        key,
	input  logic              end_of_input,
	input  ule_pkg::dp_stat_t stat,
	output ule_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_TEST,
		ST_COPY_CHK,
		ST_COPY_WR,
		ST_INS_CHK,
		ST_INS_WR,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_EMPTY,
		ST_END
	} state_t;

	typedef enum logic [1:0] {
		ESC_IDLE,
		ESC_SEEN,
		ESC_CSI
	} esc_t;

	typedef enum logic [1:0] {
		MODE_LEFT,
		MODE_RIGHT,
		MODE_BKSP
	} mode_t;

	typedef enum logic [1:0] {
		ACT_PASS,
		ACT_EAT,
		ACT_LEFT,
		ACT_RIGHT
	} act_t;

	state_t state_q, state_d;
	esc_t   esc_q, esc_d, esc_step;
	mode_t  mode_q, mode_d;
	logic   ended_q, ended_d;
	act_t   act;
	logic   fire;
	logic   scan_more;

	assign ready = (state_q == ST_IDLE);
	assign fire  = valid && ready;

	// Escape parser step for the key at the input
	always_comb begin
		act      = ACT_PASS;
		esc_step = esc_q;
		if (key == ule_pkg::KEY_LEFT) begin
			esc_step = ESC_IDLE;
			act      = ACT_LEFT;
		end else if (key == ule_pkg::KEY_RIGHT) begin
			esc_step = ESC_IDLE;
			act      = ACT_RIGHT;
		end else begin
			unique case (esc_q)
				ESC_IDLE: begin
					if (key == ule_pkg::KEY_ESC) begin
						esc_step = ESC_SEEN;
						act      = ACT_EAT;
					end
				end
				ESC_SEEN: begin
					act      = ACT_EAT;
					esc_step = (key == ule_pkg::KEY_CSI || key == ule_pkg::KEY_SS3) ?
					           ESC_CSI : ESC_IDLE;
				end
				ESC_CSI: begin
					act = ACT_EAT;
					if (key >= ule_pkg::KEY_FIN_LO && key <= ule_pkg::KEY_FIN_HI) begin
						esc_step = ESC_IDLE;
						if (key == ule_pkg::KEY_FIN_LEFT) begin
							act = ACT_LEFT;
						end else if (key == ule_pkg::KEY_FIN_RIGHT) begin
							act = ACT_RIGHT;
						end
					end
				end
				default: begin
					act      = ACT_EAT;
					esc_step = ESC_IDLE;
				end
			endcase
		end
	end

	// Scan continues over continuation bytes
	assign scan_more = stat.rd_cont &&
	                   ((mode_q == MODE_RIGHT) ? !stat.ptr_at_len : !stat.ptr_zero);

	// Next-state and command logic
	always_comb begin
		state_d  = state_q;
		esc_d    = esc_q;
		mode_d   = mode_q;
		ended_d  = ended_q;
		cmd.op   = ule_pkg::DP_NOP;
		cmd.data = key[7:0];
		unique case (state_q)
			ST_IDLE: begin
				if (fire && !ended_q) begin
					if (end_of_input ||
					    ((key == ule_pkg::KEY_EOT || key == ule_pkg::KEY_SUB) &&
					     stat.len_zero)) begin
						ended_d = 1'b1;
						state_d = ST_END;
					end else if (key <= ule_pkg::KEY_RIGHT) begin
						esc_d = esc_step;
						unique case (act)
							ACT_LEFT: begin
								if (!stat.cur_zero) begin
									cmd.op  = ule_pkg::DP_LOAD_LEFT;
									mode_d  = MODE_LEFT;
									state_d = ST_SCAN_RD;
								end
							end
							ACT_RIGHT: begin
								if (!stat.cur_at_end) begin
									cmd.op  = ule_pkg::DP_LOAD_RIGHT;
									mode_d  = MODE_RIGHT;
									state_d = ST_SCAN_RD;
								end
							end
							ACT_PASS: begin
								if (key == ule_pkg::KEY_LF || key == ule_pkg::KEY_CR) begin
									if (stat.len_zero) begin
										state_d = ST_EMPTY;
									end else begin
										cmd.op  = ule_pkg::DP_EMIT_START;
										state_d = ST_EMIT_RD;
									end
								end else if (key == ule_pkg::KEY_BS ||
								             key == ule_pkg::KEY_DEL) begin
									if (!stat.cur_zero) begin
										cmd.op  = ule_pkg::DP_LOAD_LEFT;
										mode_d  = MODE_BKSP;
										state_d = ST_SCAN_RD;
									end
								end else if (key == ule_pkg::KEY_TAB ||
								             key >= ule_pkg::KEY_SPACE) begin
									if (!stat.len_full) begin
										cmd.op  = ule_pkg::DP_INS_START;
										state_d = ST_INS_CHK;
									end
								end
							end
							default: ;
						endcase
					end
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_TEST;
			ST_SCAN_TEST: begin
				if (scan_more) begin
					cmd.op  = (mode_q == MODE_RIGHT) ? ule_pkg::DP_PTR_INC : ule_pkg::DP_PTR_DEC;
					state_d = ST_SCAN_RD;
				end else if (mode_q == MODE_BKSP) begin
					cmd.op  = ule_pkg::DP_BKSP_START;
					state_d = ST_COPY_CHK;
				end else begin
					cmd.op  = ule_pkg::DP_SET_CUR;
					state_d = ST_IDLE;
				end
			end
			ST_COPY_CHK: begin
				if (stat.ptr_at_len) begin
					cmd.op  = ule_pkg::DP_BKSP_END;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_COPY_WR;
				end
			end
			ST_COPY_WR: begin
				cmd.op  = ule_pkg::DP_COPY;
				state_d = ST_COPY_CHK;
			end
			ST_INS_CHK: begin
				if (stat.dst_at_cur) begin
					cmd.op  = ule_pkg::DP_INS_END;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_INS_WR;
				end
			end
			ST_INS_WR: begin
				cmd.op  = ule_pkg::DP_SHIFT;
				state_d = ST_INS_CHK;
			end
			ST_EMIT_RD: state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: begin
				if (stat.out_free) begin
					cmd.op  = ule_pkg::DP_EMIT_BYTE;
					state_d = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_EMPTY: begin
				if (stat.out_free) begin
					cmd.op  = ule_pkg::DP_EMIT_EMPTY;
					state_d = ST_IDLE;
				end
			end
			ST_END: begin
				if (stat.out_free) begin
					cmd.op  = ule_pkg::DP_EMIT_END;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			esc_q   <= ESC_IDLE;
			mode_q  <= MODE_LEFT;
			ended_q <= 1'b0;
		end else begin
			state_q <= state_d;
			esc_q   <= esc_d;
			mode_q  <= mode_d;
			ended_q <= ended_d;
		end
	end

endmodule

### rtl/core/utf8_line_editor_core.sv
// ============================================================================
// utf8_line_editor_core: UTF-8 line editor with ANSI arrow keys
// Work per key: a key that only moves the escape parser is handled in idle;
// cursor moves read and test each byte scanned, insert and backspace check
// and move each tail byte, enter reads and outputs each line byte, each byte
// waiting for the registered store read. Output waits while the result
// register is not free; one key in work at a time.
// Reset: arst_n clears length, cursor, escape state and the end flag at once.
// ============================================================================
module utf8_line_editor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [8:0] key, [15:9] zero
	input  logic        s_axis_tuser,  // [0] end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] line_byte, [8] line_empty, [15:9] zero
	output logic        m_axis_tuser,  // [0] kind
	output logic        m_axis_tlast
);

	ule_pkg::dp_cmd_t  cmd;
	ule_pkg::dp_stat_t stat;
	logic [7:0]        out_byte;
	logic              out_empty;

	ule_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (s_axis_tvalid),
		.ready        (s_axis_tready),
		.key          (s_axis_tdata[8:0]),
		.end_of_input (s_axis_tuser),
		.stat         (stat),
		.cmd          (cmd)
	);

	ule_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_kind  (m_axis_tuser),
		.out_byte  (out_byte),
		.out_empty (out_empty),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, out_empty, out_byte};

	// The result register is loaded only when it is free
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == ule_pkg::DP_EMIT_BYTE || cmd.op == ule_pkg::DP_EMIT_EMPTY ||
		 cmd.op == ule_pkg::DP_EMIT_END) |-> stat.out_free)
		else $error("result register overwritten");

	// Nothing follows the end-of-input beat
	a_end_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser) |=> !m_axis_tvalid)
		else $error("beat after end of input");

	// Only line bytes of a non-empty line can be non-final
	a_nonlast_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (!m_axis_tuser && !m_axis_tdata[8]))
		else $error("non-final beat that is not a line byte");

endmodule
